// ===== rtl/pnls_pkg.sv =====
// shared types and constants for the path nearest and lookahead search unit
// no dependencies
package pnls_pkg;

    localparam int unsigned IDX_W = 10;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        command;
        logic [9:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic        point_last;
        logic        new_path;
        logic [31:0] robot_x;
        logic [31:0] robot_y;
        logic [30:0] lookahead_min;
        logic [9:0]  lookahead_start;
    } t_in_beat;

    typedef struct packed {
        logic        path_valid;
        logic [9:0]  closest_index;
        logic [9:0]  lookahead_index;
        logic [31:0] lookahead_x;
        logic [31:0] lookahead_y;
        logic [31:0] lookahead_dist;
    } t_out_beat;

endpackage

// ===== rtl/pnls_dist.sv =====
// squared distance unit: both 33x33 squares registered, their sum combinational
// depends on pnls_pkg
module pnls_dist (
    input  logic        i_clk,
    input  logic [32:0] i_dx,
    input  logic [32:0] i_dy,
    output logic [65:0] o_dsq
);
    import pnls_pkg::*;

    logic [32:0] w_ax, w_ay;
    logic [65:0] r_sx, r_sy;

    assign w_ax = i_dx[32] ? 33'(-i_dx) : i_dx;
    assign w_ay = i_dy[32] ? 33'(-i_dy) : i_dy;

    always_ff @(posedge i_clk) begin
        r_sx <= 66'(w_ax) * 66'(w_ax);
        r_sy <= 66'(w_ay) * 66'(w_ay);
    end

    // squares wrap at 64 bits, the sum keeps its carry
    logic [64:0] w_sum;
    assign w_sum = {1'b0, r_sx[63:0]} + {1'b0, r_sy[63:0]};
    assign o_dsq = {1'b0, w_sum};
endmodule

// ===== rtl/pnls_isqrt.sv =====
// bit-pair iterative integer square root of a 64-bit value, one step a cycle
// depends on pnls_pkg
module pnls_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    import pnls_pkg::*;

    logic [63:0] r_n, r_res, r_bit;
    logic        r_run;
    logic [64:0] w_tr;

    assign w_tr   = 65'(r_res) + 65'(r_bit);
    assign o_root = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_n   <= i_val;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end else if (r_run) begin
                if (r_bit == '0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    if (65'(r_n) >= w_tr) begin
                        r_n   <= r_n - w_tr[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end
endmodule

// ===== rtl/path_nearest_and_lookahead_search_unit.sv =====
// top level: path store, sequencer walking the shared distance unit, square root
// depends on pnls_pkg, pnls_dist, pnls_isqrt
// A load passes through the load state and the output state; a query on an empty path
// passes through the read state and the output state. A query visits each point in the
// nearest pass (from the tracking index to the end), then in the lookahead pass each point
// from the lookahead start until one lies at least the minimum distance away, reads
// the last point when it falls back to it, and ends with the final distance and square
// root. Points are read from the point memory and passed through the squared-distance
// unit one point at a time. busy is high for the whole item; the result beat shows on
// o_done for one cycle and cannot be held off.
module path_nearest_and_lookahead_search_unit #(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned COORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pnls_pkg::t_in_beat  i_beat,
    output logic                o_done,
    output pnls_pkg::t_out_beat o_beat
);
    import pnls_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_NRD, S_NWAIT, S_NCMP, S_LRD, S_LWAIT, S_LCMP,
        S_FWAIT, S_FDIST, S_SQRT, S_OUT
    } t_state;

    t_state      r_state;
    t_in_beat    r_in;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_track, r_i, r_best, r_lh;
    logic [64:0]   r_bdsq;
    logic          r_have;
    logic [31:0]   r_mx [MAX_POINTS];
    logic [31:0]   r_my [MAX_POINTS];
    logic [31:0]   r_rx, r_ry;
    logic [AW-1:0] r_addr;
    logic [1:0]    r_wcnt;
    logic [65:0]   w_dsq;
    logic [61:0]   r_md2;
    logic          r_sq_go;
    logic          w_sq_done;
    logic [31:0]   w_root;
    logic [64:0]   r_fdsq;

    function automatic logic [32:0] f_sext(input logic [31:0] v);
        logic [31:0] m;
        m = v;
        if (COORD_BITS < 32) begin
            m = 32'($signed(v << (32 - COORD_BITS)) >>> (32 - COORD_BITS));
        end
        return {m[31], m};
    endfunction

    always_ff @(posedge i_clk) begin
        r_rx <= r_mx[r_addr];
        r_ry <= r_my[r_addr];
        if (r_state == S_LOAD && 32'(r_in.point_index) < MAX_POINTS) begin
            r_mx[AW'(r_in.point_index)] <= 32'(f_sext(r_in.point_x));
            r_my[AW'(r_in.point_index)] <= 32'(f_sext(r_in.point_y));
        end
    end

    pnls_dist u_dist (
        .i_clk (i_clk),
        .i_dx  (33'(f_sext(r_rx) - f_sext(r_in.robot_x))),
        .i_dy  (33'(f_sext(r_ry) - f_sext(r_in.robot_y))),
        .o_dsq (w_dsq)
    );

    pnls_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_val   (r_fdsq[63:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    logic [AW-1:0] w_last;
    assign w_last = AW'(r_count - CW'(1));
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_track <= '0;
            o_done  <= 1'b0;
            r_sq_go <= 1'b0;
        end else begin
            o_done  <= 1'b0;
            r_sq_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in    <= i_beat;
                        r_md2   <= 62'(i_beat.lookahead_min) * 62'(i_beat.lookahead_min);
                        r_state <= (i_beat.command == CMD_LOAD) ? S_LOAD : S_NRD;
                    end
                end
                S_LOAD: begin
                    if (32'(r_in.point_index) < MAX_POINTS && r_in.point_last)
                        r_count <= CW'(r_in.point_index) + CW'(1);
                    if (r_in.new_path) r_track <= '0;
                    r_state <= S_OUT;
                    o_beat  <= '0;
                end
                S_NRD: begin
                    o_beat <= '0;
                    if (r_count == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i    <= (r_track > w_last) ? w_last : r_track;
                        r_addr <= (r_track > w_last) ? w_last : r_track;
                        r_best <= (r_track > w_last) ? w_last : r_track;
                        r_have <= 1'b0;
                        r_wcnt <= '0;
                        r_state <= S_NWAIT;
                    end
                end
                S_NWAIT: begin
                    r_wcnt <= r_wcnt + 2'd1;
                    if (r_wcnt == 2'd2) r_state <= S_NCMP;
                end
                S_NCMP: begin
                    if (!r_have || w_dsq[64:0] < r_bdsq) begin
                        r_have <= 1'b1;
                        r_bdsq <= w_dsq[64:0];
                        r_best <= r_i;
                    end
                    r_wcnt <= '0;
                    if (r_i == w_last) begin
                        r_state <= S_LRD;
                    end else begin
                        r_i    <= r_i + AW'(1);
                        r_addr <= r_i + AW'(1);
                        r_state <= S_NWAIT;
                    end
                end
                S_LRD: begin
                    r_track <= r_best;
                    r_lh    <= w_last;
                    r_wcnt  <= '0;
                    if (32'(r_in.lookahead_start) > 32'(w_last)) begin
                        r_addr  <= w_last;
                        r_state <= S_FWAIT;
                    end else begin
                        r_i     <= AW'(r_in.lookahead_start);
                        r_addr  <= AW'(r_in.lookahead_start);
                        r_state <= S_LWAIT;
                    end
                end
                S_LWAIT: begin
                    r_wcnt <= r_wcnt + 2'd1;
                    if (r_wcnt == 2'd2) r_state <= S_LCMP;
                end
                S_LCMP: begin
                    r_wcnt <= '0;
                    if (w_dsq[64] || w_dsq[63:0] >= 64'(r_md2)) begin
                        r_lh    <= r_i;
                        r_state <= S_FDIST;
                    end else if (r_i == w_last) begin
                        r_addr  <= w_last;
                        r_state <= S_FWAIT;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_addr  <= r_i + AW'(1);
                        r_state <= S_LWAIT;
                    end
                end
                S_FWAIT: begin
                    r_wcnt <= r_wcnt + 2'd1;
                    if (r_wcnt == 2'd2) r_state <= S_FDIST;
                end
                S_FDIST: begin
                    r_fdsq  <= w_dsq[64:0];
                    r_sq_go <= 1'b1;
                    o_beat.path_valid      <= 1'b1;
                    o_beat.closest_index   <= 10'(r_track);
                    o_beat.lookahead_index <= 10'(r_lh);
                    o_beat.lookahead_x     <= r_rx;
                    o_beat.lookahead_y     <= r_ry;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        o_beat.lookahead_dist <= r_fdsq[64] ? 32'hFFFF_FFFF : w_root;
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (r_in.command == CMD_LOAD) o_beat.path_valid <= (r_count != '0);
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/pnls_checker.sv =====
// port-level checks on the search unit's command handshake and results
// depends on pnls_pkg; bound to path_nearest_and_lookahead_search_unit
module pnls_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input pnls_pkg::t_out_beat o_beat
);
    import pnls_pkg::*;

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item not taken");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_beat.path_valid |-> o_beat.lookahead_dist == '0)
        else $error("empty path with distance");
endmodule

bind path_nearest_and_lookahead_search_unit pnls_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_beat  (o_beat)
);

// ===== test/path_nearest_and_lookahead_search_unit_tb.sv =====
// testbench for the path nearest and lookahead search unit: path loads and queries
// against a behavioural predictor, results checked field by field in order
// depends on pnls_pkg and path_nearest_and_lookahead_search_unit
module path_nearest_and_lookahead_search_unit_tb;
    import pnls_pkg::*;

    localparam int NPTS = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_beat i_beat = '0;
    logic o_done;
    t_out_beat o_beat;

    path_nearest_and_lookahead_search_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_beat(i_beat), .o_done(o_done), .o_beat(o_beat)
    );

    always #1 i_clk = ~i_clk;

    logic signed [31:0] path_x [NPTS];
    logic signed [31:0] path_y [NPTS];
    int unsigned point_count;
    int unsigned tracking_idx;
    int unsigned loaded_len;
    t_out_beat pending_results[$];
    int mismatches;
    longint cycles;
    int burst_left;

    function automatic logic [64:0] dist_sq(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] rx, logic signed [31:0] ry);
        logic signed [33:0] dx, dy;
        logic [32:0] ax, ay;
        dx = px - rx;
        dy = py - ry;
        ax = 33'(dx < 0 ? -dx : dx);
        ay = 33'(dy < 0 ? -dy : dy);
        return {1'b0, 64'(ax * ax)} + {1'b0, 64'(ay * ay)};
    endfunction

    function automatic logic [32:0] floor_sqrt(logic [64:0] n);
        logic [32:0] r;
        logic [65:0] t;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            t = {1'b0, r | (33'd1 << b)};
            if (t * t <= {1'b0, n}) r = r | (33'd1 << b);
        end
        return r;
    endfunction

    function automatic t_out_beat predict_search(t_in_beat b);
        t_out_beat r;
        int unsigned last, best, lh;
        logic [64:0] bd, d, md2;
        logic [32:0] s;
        r = '0;
        if (b.command == CMD_LOAD) begin
            path_x[b.point_index] = b.point_x;
            path_y[b.point_index] = b.point_y;
            if (b.point_last) point_count = b.point_index + 1;
            if (b.new_path) tracking_idx = 0;
            r.path_valid = point_count > 0;
            return r;
        end
        if (point_count == 0) return r;
        last = point_count - 1;
        if (tracking_idx > last) tracking_idx = last;
        best = tracking_idx;
        bd = dist_sq(path_x[best], path_y[best], b.robot_x, b.robot_y);
        for (int unsigned i = tracking_idx + 1; i <= last; i++) begin
            d = dist_sq(path_x[i], path_y[i], b.robot_x, b.robot_y);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        tracking_idx = best;
        md2 = 65'(b.lookahead_min) * 65'(b.lookahead_min);
        lh = last;
        for (int unsigned i = b.lookahead_start; i <= last; i++) begin
            if (dist_sq(path_x[i], path_y[i], b.robot_x, b.robot_y) >= md2) begin
                lh = i;
                break;
            end
        end
        d = dist_sq(path_x[lh], path_y[lh], b.robot_x, b.robot_y);
        s = floor_sqrt(d);
        r.path_valid = 1'b1;
        r.closest_index = best[9:0];
        r.lookahead_index = lh[9:0];
        r.lookahead_x = path_x[lh];
        r.lookahead_y = path_y[lh];
        r.lookahead_dist = (d[64] || s[32]) ? 32'hFFFF_FFFF : s[31:0];
        return r;
    endfunction

    // burst-gapped sender, one beat per call
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_beat <= b;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_search(b));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    task automatic load_point(int unsigned idx, logic signed [31:0] x, logic signed [31:0] y,
                              logic last_flag, logic np);
        t_in_beat b;
        b = '0;
        b.command = CMD_LOAD;
        b.point_index = 10'(idx);
        b.point_x = x;
        b.point_y = y;
        b.point_last = last_flag;
        b.new_path = np;
        b.robot_x = $urandom();
        b.robot_y = $urandom();
        b.lookahead_min = 31'($urandom());
        b.lookahead_start = 10'($urandom());
        send_beat(b);
        if (last_flag) loaded_len = idx + 1;
    endtask

    task automatic query(logic signed [31:0] rx, logic signed [31:0] ry, logic [30:0] md,
                         logic [9:0] ls);
        t_in_beat b;
        b = '0;
        b.command = CMD_QUERY;
        b.robot_x = rx;
        b.robot_y = ry;
        b.lookahead_min = md;
        b.lookahead_start = ls;
        b.point_index = 10'($urandom());
        b.point_x = $urandom();
        b.point_y = $urandom();
        b.point_last = 1'($urandom());
        b.new_path = 1'($urandom());
        send_beat(b);
    endtask

    // load a path of n points, all slots written so no read of a stale slot
    task automatic load_path(int unsigned n, logic np);
        for (int unsigned i = 0; i < n; i++)
            load_point(i, rand_coord(), rand_coord(), i == n - 1, np && i == 0);
    endtask

    task automatic test_empty_and_extremes;
        query(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 10'h3FF);
        load_point(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1);
        query(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 10'd0);
        query(32'sh8000_0000, 32'sh8000_0000, 31'd0, 10'h3FF);
        load_point(1, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0);
        query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 10'd1);
        load_point(2, 32'sd0, 32'sd0, 1'b1, 1'b0);
        load_point(3, 32'sd4096, 32'sd0, 1'b1, 1'b0);
        load_point(4, 32'sd4096, 32'sd0, 1'b1, 1'b0);
        query(32'sd4096, 32'sd0, 31'd4096, 10'd2);
        query(32'sd4096, 32'sd0, 31'd0, 10'd0);
        load_point(1, 32'sd5, 32'sd5, 1'b1, 1'b1);
        query(32'sd0, 32'sd0, 31'd100, 10'd900);
        drain();
    endtask

    task automatic test_tracking_clamp;
        load_path(12, 1'b1);
        query(32'sd0, 32'sd0, 31'd1000, 10'd0);
        query(rand_coord(), rand_coord(), 31'd50000, 10'd5);
        load_point(3, rand_coord(), rand_coord(), 1'b1, 1'b0);
        query(rand_coord(), rand_coord(), 31'd0, 10'd1023);
        drain();
    endtask

    task automatic test_random_mix;
        int n;
        int len;
        n = 0;
        while (n < 200) begin
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(1, 16);
                    load_path(len, 1'($urandom_range(0, 1)));
                    n = n + len;
                end
                1: begin
                    if (loaded_len > 0)
                        load_point($urandom_range(0, loaded_len - 1), rand_coord(), rand_coord(),
                                   $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
                    n++;
                end
                default: begin
                    query(rand_coord(), rand_coord(),
                          $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 150000)),
                          $urandom_range(0, 7) == 0 ? 10'($urandom()) : 10'($urandom_range(0, 16)));
                    n++;
                end
            endcase
            if ($urandom_range(0, 60) == 0) drain();
        end
        drain();
    endtask

    task automatic test_long_path;
        load_path(48, 1'b1);
        query(rand_coord(), rand_coord(), 31'($urandom()), 10'd0);
        query(32'sd0, 32'sd0, 31'h7FFF_FFFF, 10'd0);
        drain();
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", o_beat);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_beat.path_valid !== exp_r.path_valid
                    || o_beat.closest_index !== exp_r.closest_index
                    || o_beat.lookahead_index !== exp_r.lookahead_index
                    || o_beat.lookahead_x !== exp_r.lookahead_x
                    || o_beat.lookahead_y !== exp_r.lookahead_y
                    || o_beat.lookahead_dist !== exp_r.lookahead_dist) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_r, o_beat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("path_nearest_and_lookahead_search_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        point_count = 0;
        tracking_idx = 0;
        loaded_len = 0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_extremes();
        test_tracking_clamp();
        test_random_mix();
        test_long_path();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("path_nearest_and_lookahead_search_unit_tb: clean");
        else
            $display("path_nearest_and_lookahead_search_unit_tb: errors");
        $finish;
    end

endmodule
